### rtl/lstc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link slot target controller package
// Shared widths, register and kind codes, controller constants, the queue
// item layout and the link to state slot mapping.
// ----------------------------------------------------------------------------
package lstc_pkg;

  // Number of links that keep controller state.
  localparam int LINKS = 16;
  localparam int IDX_W = (LINKS > 1) ? $clog2(LINKS) : 1;

  // Field widths.
  localparam int LINK_W  = 4;
  localparam int MSG_W   = 10;
  localparam int SLOT_W  = 8;
  localparam int ALPHA_W = 9;
  localparam int FRESH_W = 16;
  localparam int AVG_W   = 18;
  localparam int IDLE_W  = 16;
  localparam int PID_W   = 16;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;
  localparam logic [FRESH_W-1:0] FRESH_RESET = 16'd28;

  // Alpha saturates at one (256/256); the idle count saturates below all ones.
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;
  localparam logic [IDLE_W-1:0]  IDLE_MAX  = 16'hFFFE;

  // PID gains, all scaled by 1/128. The proportional gain is zero for a
  // positive error, so it does not appear in that branch.
  localparam int KI_GAIN     = 30;
  localparam int KD_GAIN_POS = 26;
  localparam int KP_GAIN_NEG = 50;
  localparam int KD_GAIN_NEG = 38;
  localparam int PID_SHIFT   = 7;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_ALPHA     = 2'd1,
    REG_FRESHNESS = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_EWMA = 1'b0,
    KIND_PID  = 1'b1
  } kind_t;

  // One classified transaction waiting for the back part.
  typedef struct packed {
    kind_t              kind;
    logic [LINK_W-1:0]  link;
    logic [IDX_W-1:0]   idx;
    logic [MSG_W-1:0]   msg_in;
    logic [MSG_W-1:0]   msg_out;
    logic [SLOT_W-1:0]  slots;
    logic [ALPHA_W-1:0] alpha;
  } item_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Maps a link number onto its state slot (link modulo LINKS).
  function automatic logic [IDX_W-1:0] link_to_idx(input logic [LINK_W-1:0] link);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << LINK_W); k++) begin
      if (link == LINK_W'(k)) r = IDX_W'(k % LINKS);
    end
    return r;
  endfunction

endpackage

### rtl/lstc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link slot target controller front part
// Holds the configuration registers, accepts input transactions and tags
// each one with its controller kind, state slot and clamped weight.
// ----------------------------------------------------------------------------
module lstc_front import lstc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  queue_stat_t           q_stat,
  output logic                  push,
  output item_t                 push_item,
  output logic [FRESH_W-1:0]    min_freshness
);

  kind_t              mode;
  logic [ALPHA_W-1:0] alpha_q8;
  logic [LINK_W-1:0]  link;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= KIND_EWMA;
      alpha_q8      <= ALPHA_RESET;
      min_freshness <= FRESH_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MODE:      mode          <= kind_t'(cfg_data[0]);
        REG_ALPHA:     alpha_q8      <= cfg_data[ALPHA_W-1:0];
        REG_FRESHNESS: min_freshness <= cfg_data[FRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && !q_stat.full;
  assign link     = s_tdata[LINK_W-1:0];

  always_comb begin
    push_item.kind    = mode;
    push_item.link    = link;
    push_item.idx     = link_to_idx(link);
    push_item.msg_in  = s_tdata[LINK_W +: MSG_W];
    push_item.msg_out = s_tdata[LINK_W + MSG_W +: MSG_W];
    push_item.slots   = s_tdata[LINK_W + 2 * MSG_W +: SLOT_W];
    // A weight above one behaves as one.
    push_item.alpha   = (alpha_q8 > ALPHA_MAX) ? ALPHA_MAX : alpha_q8;
  end

endmodule

### rtl/lstc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link slot target controller queue
// Short first-in first-out buffer of classified transactions between the
// front and back parts.
// ----------------------------------------------------------------------------
module lstc_queue import lstc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       pop_item,
  output queue_stat_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  assign pop_item     = entries[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != CNT_W'(QUEUE_DEPTH))
    else $error("queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/lstc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link slot target controller back part
// Per-link state update, then error and gain stages and the output
// register that drives the result stream.
// ----------------------------------------------------------------------------
module lstc_back import lstc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_stat_t           q_stat,
  input  item_t                 it,
  output logic                  pop,
  input  logic [FRESH_W-1:0]    min_freshness,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  // Per-link state.
  logic [AVG_W-1:0]  avg_mem   [LINKS];
  logic [IDLE_W-1:0] idle_mem  [LINKS];
  logic [PID_W-1:0]  integ_mem [LINKS];
  logic [PID_W-1:0]  prev_mem  [LINKS];

  // Update stage.
  logic [AVG_W-1:0]         avg_old;
  logic [IDLE_W-1:0]        idle_old;
  logic signed [PID_W-1:0]  integ_old;
  logic signed [PID_W-1:0]  prev_old;
  logic signed [AVG_W:0]    avg_diff;
  logic signed [AVG_W+10:0] avg_prod;
  logic signed [AVG_W+2:0]  avg_sum;
  logic [AVG_W-1:0]         avg_next;
  logic [IDLE_W-1:0]        idle_next;
  logic                     stale_next;
  logic signed [MSG_W:0]    e_next;
  logic signed [PID_W-1:0]  e_wide;
  logic signed [PID_W-1:0]  d_next;
  logic signed [PID_W-1:0]  i_next;

  // Stage one registers.
  logic                    s1_valid;
  kind_t                   s1_kind;
  logic [LINK_W-1:0]       s1_link;
  logic [SLOT_W-1:0]       s1_slots;
  logic                    s1_stale;
  logic [AVG_W-1:0]        s1_avg;
  logic signed [MSG_W:0]   s1_e;
  logic signed [PID_W-1:0] s1_i;
  logic signed [PID_W-1:0] s1_d;

  // Stage two: EWMA change or PID numerator.
  logic signed [AVG_W+1:0] err;
  logic signed [11:0]      ceil_q;
  logic signed [11:0]      change;
  logic signed [23:0]      num;
  logic                    s2_valid;
  kind_t                   s2_kind;
  logic [LINK_W-1:0]       s2_link;
  logic [SLOT_W-1:0]       s2_slots;
  logic                    s2_stale;
  logic signed [23:0]      s2_val;

  // Final stage.
  logic signed [23:0]     num_adj;
  logic signed [16:0]     delta;
  logic signed [16:0]     total;
  logic signed [16:0]     low_limit;
  logic [SLOT_W-1:0]      target;
  logic                   o_valid;
  logic [LINK_W-1:0]      o_link;
  logic [SLOT_W-1:0]      o_target;
  logic                   o_stale;

  logic out_free;
  logic s2_free;
  logic s1_free;

  assign out_free = !o_valid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign pop      = !q_stat.empty && s1_free;

  // State read and next state.
  always_comb begin
    avg_old   = avg_mem[it.idx];
    idle_old  = idle_mem[it.idx];
    integ_old = integ_mem[it.idx];
    prev_old  = prev_mem[it.idx];

    // new = old + floor((in * 256 - old) * alpha / 256)
    avg_diff  = $signed({1'b0, it.msg_in, 8'b0}) - $signed({1'b0, avg_old});
    avg_prod  = (AVG_W + 11)'(avg_diff) * (AVG_W + 11)'($signed({1'b0, it.alpha}));
    avg_sum   = $signed({3'b0, avg_old}) + (AVG_W + 3)'(avg_prod >>> 8);
    avg_next  = avg_sum[AVG_W-1:0];

    stale_next = idle_old > min_freshness;
    if (it.msg_in != '0) begin
      idle_next = '0;
    end else if (idle_old < IDLE_MAX) begin
      idle_next = idle_old + 1'b1;
    end else begin
      idle_next = idle_old;
    end

    e_next = $signed({1'b0, it.msg_in}) - $signed({1'b0, it.msg_out});
    e_wide = PID_W'(e_next);
    d_next = e_wide - prev_old;
    i_next = integ_old + e_wide;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LINKS; k++) begin
        avg_mem[k]   <= '0;
        idle_mem[k]  <= '0;
        integ_mem[k] <= '0;
        prev_mem[k]  <= '0;
      end
    end else if (pop) begin
      case (it.kind)
        KIND_EWMA: begin
          avg_mem[it.idx]  <= avg_next;
          idle_mem[it.idx] <= idle_next;
        end
        KIND_PID: begin
          integ_mem[it.idx] <= i_next;
          prev_mem[it.idx]  <= e_wide;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind  <= it.kind;
      s1_link  <= it.link;
      s1_slots <= it.slots;
      s1_stale <= (it.kind == KIND_EWMA) && stale_next;
      s1_avg   <= avg_next;
      s1_e     <= e_next;
      s1_i     <= i_next;
      s1_d     <= d_next;
    end
  end

  // EWMA: move by ceil(err / 256) above the allocation, by that plus one
  // when more than two slots below it. PID: gain sum before the scaling.
  always_comb begin
    err    = $signed({2'b0, s1_avg}) - $signed({4'b0, s1_slots, 8'b0});
    ceil_q = 12'((err + 20'sd255) >>> 8);
    if (err > 0) begin
      change = ceil_q;
    end else if (err < -20'sd512) begin
      change = ceil_q + 12'sd1;
    end else begin
      change = '0;
    end
    if (s1_e > 0) begin
      num = 24'(KI_GAIN * s1_i) + 24'(KD_GAIN_POS * s1_d);
    end else begin
      num = 24'(KP_GAIN_NEG * s1_e) + 24'(KI_GAIN * s1_i) + 24'(KD_GAIN_NEG * s1_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_kind  <= s1_kind;
      s2_link  <= s1_link;
      s2_slots <= s1_slots;
      s2_stale <= s1_stale;
      s2_val   <= (s1_kind == KIND_PID) ? num : 24'(change);
    end
  end

  // Scaling truncates toward zero, then the target is zeroed when stale or else clamped.
  always_comb begin
    num_adj = s2_val + ((s2_val < 0) ? 24'sd127 : 24'sd0);
    if (s2_kind == KIND_PID) begin
      delta     = 17'(num_adj >>> PID_SHIFT);
      low_limit = 17'sd1;
    end else begin
      delta     = 17'(s2_val);
      low_limit = 17'sd0;
    end
    total = $signed({9'b0, s2_slots}) + delta;
    if (s2_stale) begin
      target = '0;
    end else if (total < low_limit) begin
      target = SLOT_W'(low_limit);
    end else if (total > 17'sd255) begin
      target = '1;
    end else begin
      target = total[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      o_link   <= s2_link;
      o_target <= target;
      o_stale  <= s2_stale;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {{(OUT_DATA_W - LINK_W - SLOT_W){1'b0}}, o_target, o_link};
  assign m_tuser  = o_stale;

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_stale |-> o_target == '0)
    else $error("stale result with nonzero target");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid && $stable(s1_link))
    else $error("stage one lost a stalled transaction");

endmodule

### rtl/link_slot_target_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link slot target controller
// Per-link slot target from message counts, by EWMA or asymmetric PID.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output is not
// stalled and gives one result transaction for each, in order. The rate is
// set by the per-link state update, which reads and writes the link's
// average, idle count, error integral and previous error in the same cycle,
// so consecutive transactions for the same link need no forwarding. A
// two-entry queue separates the input side from the computing pipeline and
// an output register holds a finished result, so either stream side can
// stall without stopping the other at once.
// Configuration writes go through cfg_wen, cfg_index and cfg_data and are
// meant to happen only while no transaction is in flight. Mode 0 selects
// the EWMA controller, which forces the target to zero and flags the result
// on m_tuser when a link has been idle longer than min_freshness; mode 1
// selects the PID controller, whose target never drops below one.
module link_slot_target_controller import lstc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port: 0 mode, 1 alpha_q8, 2 min_freshness.
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: link, messages_in, messages_out, allocated_slots.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: link_out, slot_target, zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0: stale.
  output logic                  m_tuser
);

  queue_stat_t        q_stat;
  logic               push;
  item_t              push_item;
  logic               pop;
  item_t              pop_item;
  logic [FRESH_W-1:0] min_freshness;

  // Front part: configuration registers and classification.
  lstc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item),
    .min_freshness (min_freshness)
  );

  // Queue of classified transactions.
  lstc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back part: state update, controller arithmetic and output register.
  lstc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .it            (pop_item),
    .pop           (pop),
    .min_freshness (min_freshness),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule
